// File: hw/rtl/wplb_pkg.sv
`timescale 1ns / 1ps
package wplb_pkg;
    localparam int unsigned BOOK_LEVELS = 4096;
    localparam int unsigned IDX_W = $clog2(BOOK_LEVELS);
    localparam int unsigned HALF_WINDOW = BOOK_LEVELS / 2;
    localparam int unsigned BIT_MASK = 63;
    localparam int unsigned WORD_SHIFT = 6;
    localparam int unsigned OCC_WORDS = (BOOK_LEVELS + 63) / 64;
    localparam int unsigned WORD_W = (OCC_WORDS > 1) ? $clog2(OCC_WORDS) : 1;
    localparam int unsigned QTY_W = 31;
    localparam int unsigned CNT_W = 13;

    typedef struct packed {
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
    } req_t;

    typedef struct packed {
        logic [31:0]      bid_price;
        logic             bid_present;
        logic [31:0]      ask_price;
        logic             ask_present;
        logic [QTY_W-1:0] previous_quantity;
        logic             out_of_window;
        logic [CNT_W-1:0] bid_level_count;
        logic [CNT_W-1:0] ask_level_count;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_DECIDE, ST_OCCWR, ST_SCAN_RD, ST_SCAN_CHK, ST_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic rd_level;
        logic decide;
        logic occ_write;
        logic scan_rd;
        logic scan_chk;
        logic emit;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_done;
        logic in_window;
        logic need_occ;
        logic need_scan;
        logic scan_done;
    } sts_t;
endpackage

// File: hw/rtl/wplb_if.sv
`timescale 1ns / 1ps
interface wplb_if #(parameter int unsigned W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/wplb_ram.sv
`timescale 1ns / 1ps
module wplb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/wplb_ctrl.sv
`timescale 1ns / 1ps
module wplb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  wplb_pkg::sts_t sts,
    output wplb_pkg::cmd_t cmd
);
    import wplb_pkg::*;
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (sts.clear_done) state_next = ST_IDLE;
            ST_IDLE:     if (in_valid) state_next = ST_READ;
            ST_READ:     state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (!sts.in_window || !sts.need_occ) state_next = ST_DONE;
                else state_next = ST_OCCWR;
            end
            ST_OCCWR:    state_next = sts.need_scan ? ST_SCAN_RD : ST_DONE;
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: state_next = sts.scan_done ? ST_DONE : ST_SCAN_RD;
            ST_DONE:     if (out_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_CLEAR:    cmd.clear = 1'b1;
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_READ:     cmd.rd_level = 1'b1;
            ST_DECIDE:   cmd.decide = 1'b1;
            ST_OCCWR:    cmd.occ_write = 1'b1;
            ST_SCAN_RD:  cmd.scan_rd = 1'b1;
            ST_SCAN_CHK: cmd.scan_chk = 1'b1;
            ST_DONE:
            begin
                out_valid = 1'b1;
                cmd.emit = out_ready;
            end
            default: ;
        endcase
    end
endmodule

// File: hw/rtl/wplb_dp.sv
`timescale 1ns / 1ps
module wplb_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  wplb_pkg::req_t req,
    input  wplb_pkg::cmd_t cmd,
    output wplb_pkg::sts_t sts,
    output wplb_pkg::rsp_t rsp
);
    import wplb_pkg::*;

    logic        side_reg;
    logic [31:0] price_reg;
    logic [QTY_W-1:0] fresh_reg;
    logic [IDX_W-1:0] idx_reg;
    logic        inwin_reg;
    logic [31:0] anchor_reg;
    logic        anchor_set_reg;
    logic [31:0] bid_px_reg, ask_px_reg;
    logic        bid_valid_reg, ask_valid_reg;
    logic [CNT_W-1:0] bid_cnt_reg, ask_cnt_reg;
    logic [QTY_W-1:0] prev_reg;
    logic        need_scan_reg, set_bit_reg;
    logic [WORD_W-1:0] word_reg;
    logic [63:0] mask_reg;
    logic        scan_done_reg;
    logic [IDX_W-1:0] clr_reg;

    // qty and occupancy memories, one of each per side, zeroed by the clear pass
    logic [QTY_W-1:0] bq_rd, aq_rd;
    logic [63:0]      bo_rd, ao_rd;
    logic             q_we, o_we;
    logic             bq_we, aq_we, bo_we, ao_we;
    logic [QTY_W-1:0] q_wd;
    logic [63:0]      o_wd;
    logic [IDX_W-1:0] q_addr;
    logic [WORD_W-1:0] o_addr;

    wplb_ram #(.WIDTH(QTY_W), .DEPTH(BOOK_LEVELS)) u_bq (
        .clk(clk), .we(bq_we), .waddr(q_addr), .wdata(q_wd),
        .raddr(q_addr), .rdata(bq_rd));
    wplb_ram #(.WIDTH(QTY_W), .DEPTH(BOOK_LEVELS)) u_aq (
        .clk(clk), .we(aq_we), .waddr(q_addr), .wdata(q_wd),
        .raddr(q_addr), .rdata(aq_rd));
    wplb_ram #(.WIDTH(64), .DEPTH(OCC_WORDS)) u_bo (
        .clk(clk), .we(bo_we), .waddr(o_addr), .wdata(o_wd),
        .raddr(o_addr), .rdata(bo_rd));
    wplb_ram #(.WIDTH(64), .DEPTH(OCC_WORDS)) u_ao (
        .clk(clk), .we(ao_we), .waddr(o_addr), .wdata(o_wd),
        .raddr(o_addr), .rdata(ao_rd));

    logic [QTY_W-1:0] old_q;
    logic [63:0]      occ_word;
    logic [63:0]      bitsel;
    logic [63:0]      masked;
    logic [5:0]       pos;
    logic             found;
    logic [31:0]      scan_price;
    logic [33:0]      idx_wide;
    logic [31:0]      ld_anchor;
    logic             occ_change;

    assign old_q = side_reg ? aq_rd : bq_rd;
    assign occ_word = side_reg ? ao_rd : bo_rd;
    assign bitsel = 64'd1 << idx_reg[5:0];
    assign q_addr = cmd.clear ? clr_reg : idx_reg;
    assign o_addr = cmd.clear ? clr_reg[WORD_W-1:0] : word_reg;
    assign q_we = cmd.decide && inwin_reg && (old_q != fresh_reg);
    assign q_wd = cmd.clear ? '0 : fresh_reg;
    assign o_we = cmd.occ_write;
    assign o_wd = cmd.clear ? '0 :
                  set_bit_reg ? (occ_word | bitsel) : (occ_word & ~bitsel);
    assign bq_we = cmd.clear || (q_we && !side_reg);
    assign aq_we = cmd.clear || (q_we && side_reg);
    assign bo_we = cmd.clear || (o_we && !side_reg);
    assign ao_we = cmd.clear || (o_we && side_reg);
    assign masked = occ_word & mask_reg;
    assign ld_anchor = anchor_set_reg ? anchor_reg : req.price;
    assign idx_wide = {{2{req.price[31]}}, req.price} - {{2{ld_anchor[31]}}, ld_anchor}
                    + 34'(HALF_WINDOW);
    assign occ_change = inwin_reg && (old_q != fresh_reg) && (old_q == '0 || fresh_reg == '0);

    // priority pick within one word: highest bit for bids, lowest for asks
    always_comb
    begin
        pos = '0;
        found = |masked;
        if (side_reg)
        begin
            for (int i = 63; i >= 0; i--)
            begin
                if (masked[i]) pos = 6'(i);
            end
        end
        else
        begin
            for (int i = 0; i < 64; i++)
            begin
                if (masked[i]) pos = 6'(i);
            end
        end
    end

    assign scan_price = anchor_reg + 32'({word_reg, pos}) - 32'(HALF_WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= 1'b0;
            price_reg <= '0;
            fresh_reg <= '0;
            idx_reg <= '0;
            inwin_reg <= 1'b0;
            anchor_reg <= '0;
            anchor_set_reg <= 1'b0;
            bid_px_reg <= '0;
            ask_px_reg <= '0;
            bid_valid_reg <= 1'b0;
            ask_valid_reg <= 1'b0;
            bid_cnt_reg <= '0;
            ask_cnt_reg <= '0;
            prev_reg <= '0;
            need_scan_reg <= 1'b0;
            set_bit_reg <= 1'b0;
            word_reg <= '0;
            mask_reg <= '0;
            scan_done_reg <= 1'b0;
            clr_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.load)
            begin
                side_reg <= req.side;
                price_reg <= req.price;
                fresh_reg <= req.quantity[31] ? '0 : req.quantity[QTY_W-1:0];
                anchor_reg <= ld_anchor;
                anchor_set_reg <= 1'b1;
                inwin_reg <= (idx_wide < 34'(BOOK_LEVELS));
                idx_reg <= idx_wide[IDX_W-1:0];
                word_reg <= WORD_W'(idx_wide[IDX_W-1:WORD_SHIFT]);
            end
            if (cmd.decide)
            begin
                prev_reg <= inwin_reg ? old_q : '0;
                need_scan_reg <= 1'b0;
                if (occ_change)
                begin
                    set_bit_reg <= (old_q == '0);
                    if (old_q == '0)
                    begin
                        if (!side_reg)
                        begin
                            bid_cnt_reg <= bid_cnt_reg + 1'b1;
                            if (!bid_valid_reg || $signed(price_reg) > $signed(bid_px_reg))
                            begin
                                bid_px_reg <= price_reg;
                                bid_valid_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            ask_cnt_reg <= ask_cnt_reg + 1'b1;
                            if (!ask_valid_reg || $signed(price_reg) < $signed(ask_px_reg))
                            begin
                                ask_px_reg <= price_reg;
                                ask_valid_reg <= 1'b1;
                            end
                        end
                    end
                    else if (!side_reg)
                    begin
                        bid_cnt_reg <= bid_cnt_reg - 1'b1;
                        need_scan_reg <= bid_valid_reg && price_reg == bid_px_reg;
                    end
                    else
                    begin
                        ask_cnt_reg <= ask_cnt_reg - 1'b1;
                        need_scan_reg <= ask_valid_reg && price_reg == ask_px_reg;
                    end
                end
            end
            if (cmd.occ_write)
            begin
                // first word mask excludes the removed level and beyond
                mask_reg <= side_reg ? ~((bitsel << 1) - 64'd1) : (bitsel - 64'd1);
                if (side_reg && idx_reg[5:0] == 6'(BIT_MASK)) mask_reg <= '0;
            end
            if (cmd.scan_chk)
            begin
                mask_reg <= '1;
                scan_done_reg <= 1'b0;
                if (found)
                begin
                    if (side_reg) ask_px_reg <= scan_price;
                    else bid_px_reg <= scan_price;
                end
                else if ((!side_reg && word_reg == '0) ||
                         (side_reg && word_reg == WORD_W'(OCC_WORDS - 1)))
                begin
                    if (side_reg)
                    begin
                        ask_valid_reg <= 1'b0;
                        ask_px_reg <= '0;
                    end
                    else
                    begin
                        bid_valid_reg <= 1'b0;
                        bid_px_reg <= '0;
                    end
                end
                else
                begin
                    word_reg <= side_reg ? word_reg + 1'b1 : word_reg - 1'b1;
                end
            end
        end
    end

    assign sts.clear_done = (clr_reg == IDX_W'(BOOK_LEVELS - 1));
    assign sts.in_window = inwin_reg;
    assign sts.need_occ = occ_change;
    assign sts.need_scan = need_scan_reg;
    assign sts.scan_done = found || (!side_reg && word_reg == '0) ||
                           (side_reg && word_reg == WORD_W'(OCC_WORDS - 1));

    assign rsp.bid_price = bid_px_reg;
    assign rsp.bid_present = bid_valid_reg;
    assign rsp.ask_price = ask_px_reg;
    assign rsp.ask_present = ask_valid_reg;
    assign rsp.previous_quantity = prev_reg;
    assign rsp.out_of_window = !inwin_reg;
    assign rsp.bid_level_count = bid_cnt_reg;
    assign rsp.ask_level_count = ask_cnt_reg;

    logic unused_ok;
    assign unused_ok = cmd.scan_rd ^ cmd.rd_level ^ cmd.emit ^ scan_done_reg;
endmodule

// File: hw/rtl/windowed_price_level_book_unit.sv
`timescale 1ns / 1ps
// one update at a time: after reset the block zeroes its level and bitmap stores before it
// accepts anything. an update then passes the read level and decide states to its result,
// plus a bitmap word write when the level becomes occupied or empty; removing the best level
// adds a scan of bitmap words, a read and a check per word, up to 64 words. the next update
// can be taken in the cycle after the result leaves. the first update sets the anchor; prices
// outside anchor-2048 to anchor+2047 are flagged out of window and dropped.
module windowed_price_level_book_unit (
    input logic clk,
    input logic rst_n,
    wplb_if.sink   in_ch,
    wplb_if.source out_ch
);
    import wplb_pkg::*;
    cmd_t cmd;
    sts_t sts;
    rsp_t rsp;

    wplb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd));

    wplb_dp u_dp (
        .clk(clk), .rst_n(rst_n), .req(req_t'(in_ch.payload)), .cmd(cmd), .sts(sts),
        .rsp(rsp));

    assign out_ch.payload = rsp;
endmodule

// File: tb/sv/windowed_price_level_book_unit_test.sv
`timescale 1ns / 1ps
module windowed_price_level_book_unit_test;
    import wplb_pkg::*;

    localparam int REQ_W = $bits(req_t);
    localparam int RSP_W = $bits(rsp_t);
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    wplb_if #(.W(REQ_W)) in_ch ();
    wplb_if #(.W(RSP_W)) out_ch ();

    windowed_price_level_book_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // book mirror
    logic [QTY_W-1:0] bid_qty [BOOK_LEVELS];
    logic [QTY_W-1:0] ask_qty [BOOK_LEVELS];
    logic [31:0] top_bid, top_ask;
    logic        have_bid, have_ask;
    logic [31:0] anchor;
    logic        anchored;
    int          bid_cnt, ask_cnt;

    req_t pending_updates [$];
    rsp_t expected_quotes [$];
    int   errors = 0;
    bit   stim_done = 1'b0;
    bit   calm = 1'b0;
    longint cycles = 0;

    function automatic logic [31:0] level_price(int idx);
        return anchor + 32'(idx) - 32'(HALF_WINDOW);
    endfunction

    function automatic rsp_t apply_update(req_t u);
        rsp_t r;
        longint idx;
        logic [QTY_W-1:0] fresh, old;
        int k;
        r = '0;
        if (!anchored)
        begin
            anchor = u.price;
            anchored = 1'b1;
        end
        fresh = ($signed(u.quantity) > 0) ? u.quantity[QTY_W-1:0] : '0;
        idx = longint'($signed(u.price)) - longint'($signed(anchor)) + HALF_WINDOW;
        if (idx >= 0 && idx < BOOK_LEVELS)
        begin
            old = u.side ? ask_qty[idx] : bid_qty[idx];
            r.previous_quantity = old;
            if (old != fresh)
            begin
                if (u.side) ask_qty[idx] = fresh; else bid_qty[idx] = fresh;
                if (old == 0)
                begin
                    if (!u.side)
                    begin
                        bid_cnt++;
                        if (!have_bid || $signed(u.price) > $signed(top_bid))
                        begin
                            top_bid = u.price;
                            have_bid = 1'b1;
                        end
                    end
                    else
                    begin
                        ask_cnt++;
                        if (!have_ask || $signed(u.price) < $signed(top_ask))
                        begin
                            top_ask = u.price;
                            have_ask = 1'b1;
                        end
                    end
                end
                else if (fresh == 0)
                begin
                    if (!u.side)
                    begin
                        bid_cnt--;
                        if (have_bid && u.price == top_bid)
                        begin
                            have_bid = 1'b0;
                            top_bid = '0;
                            for (k = int'(idx) - 1; k >= 0; k--)
                                if (bid_qty[k] != 0)
                                begin
                                    have_bid = 1'b1;
                                    top_bid = level_price(k);
                                    break;
                                end
                        end
                    end
                    else
                    begin
                        ask_cnt--;
                        if (have_ask && u.price == top_ask)
                        begin
                            have_ask = 1'b0;
                            top_ask = '0;
                            for (k = int'(idx) + 1; k < BOOK_LEVELS; k++)
                                if (ask_qty[k] != 0)
                                begin
                                    have_ask = 1'b1;
                                    top_ask = level_price(k);
                                    break;
                                end
                        end
                    end
                end
            end
        end
        else
            r.out_of_window = 1'b1;
        r.bid_price = have_bid ? top_bid : '0;
        r.bid_present = have_bid;
        r.ask_price = have_ask ? top_ask : '0;
        r.ask_present = have_ask;
        r.bid_level_count = CNT_W'(bid_cnt);
        r.ask_level_count = CNT_W'(ask_cnt);
        return r;
    endfunction

    // driver: the head of the queue is the transaction on the bus until accepted
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_quotes.push_back(apply_update(req_t'(in_ch.payload)));
                void'(pending_updates.pop_front());
            end
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_updates.size() > 0)
            begin
                if (!calm && !(in_ch.valid && !in_ch.ready) && $urandom_range(0, 7) == 0)
                begin
                    send_gap <= $urandom_range(1, 17);
                    in_ch.valid <= 1'b0;
                end
                else
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.payload <= pending_updates[0];
                end
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // monitor and receiver stalls
    int hold = 0;
    always @(posedge clk)
    begin
        rsp_t got, want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = rsp_t'(out_ch.payload);
                if (expected_quotes.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_quotes.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        errors++;
                    end
                end
            end
            if (hold > 0)
            begin
                hold <= hold - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                hold <= $urandom_range(1, 17);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic req_t make_update(bit s, logic [31:0] p, logic [31:0] q);
        req_t u;
        u.side = s;
        u.price = p;
        u.quantity = q;
        return u;
    endfunction

    function automatic logic [31:0] random_qty();
        case ($urandom_range(0, 9))
            0: return 32'($urandom) | 32'h8000_0000;
            1: return '0;
            2: return 32'h7fff_ffff;
            3, 4: return $urandom;
            default: return $urandom_range(1, 50);
        endcase
    endfunction

    initial
    begin
        int i, k;
        logic [31:0] base, p;
        for (i = 0; i < BOOK_LEVELS; i++)
        begin
            bid_qty[i] = '0;
            ask_qty[i] = '0;
        end
        top_bid = '0; top_ask = '0; have_bid = 0; have_ask = 0;
        anchor = '0; anchored = 0; bid_cnt = 0; ask_cnt = 0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        base = 32'h8000_07ff;
        // directed: anchor near the negative extreme, window edges, removals
        pending_updates.push_back(make_update(0, base, 32'd10));
        pending_updates.push_back(make_update(0, base + 5, 32'h7fff_ffff));
        pending_updates.push_back(make_update(1, base + 9, 32'd3));
        pending_updates.push_back(make_update(1, base + 20, 32'd4));
        pending_updates.push_back(make_update(0, base + 5, 32'h7fff_ffff));
        pending_updates.push_back(make_update(0, base + 5, 32'd8));
        pending_updates.push_back(make_update(0, base - 2048, 32'd1));
        pending_updates.push_back(make_update(1, base + 2047, 32'd2));
        pending_updates.push_back(make_update(0, base + 2048, 32'd1));
        pending_updates.push_back(make_update(1, base - 2049, 32'd1));
        pending_updates.push_back(make_update(0, 32'h7fff_ffff, 32'd1));
        pending_updates.push_back(make_update(0, base + 5, 32'h8000_0000));
        pending_updates.push_back(make_update(0, base, 32'hffff_ffff));
        pending_updates.push_back(make_update(1, base + 9, 32'd0));
        pending_updates.push_back(make_update(1, base + 20, 32'd0));
        pending_updates.push_back(make_update(1, base + 2047, 32'd0));
        pending_updates.push_back(make_update(0, base - 2048, 32'd0));
        pending_updates.push_back(make_update(1, base + 3, 32'd0));
        pending_updates.push_back(make_update(1, base - 2048, 32'd7));
        pending_updates.push_back(make_update(0, base + 2047, 32'd7));

        // random: clustered around the anchor, with some far and wide levels
        for (i = 0; i < 400; i++)
        begin
            k = $urandom_range(0, 19);
            if (k == 0)
                p = $urandom;
            else if (k < 3)
                p = base + 32'($urandom_range(0, 4095)) - 32'd2048;
            else if (k == 3)
                p = base + 32'($urandom_range(0, 1)) * 32'd4095 - 32'd2048;
            else
                p = base + 32'($urandom_range(0, 40)) - 32'd20;
            pending_updates.push_back(make_update($urandom_range(0, 1), p, random_qty()));
            if (i == 300) calm = 1'b1;
            while (pending_updates.size() > 8) @(posedge clk);
        end
        while (pending_updates.size() > 0 || in_ch.valid) @(posedge clk);
        stim_done = 1'b1;
        calm = 1'b1;
        while (expected_quotes.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_quotes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
